/* design/ssc_pkg.sv */
// shared constants and types of the sphere contact unit
`timescale 1ns / 1ps
package ssc_pkg;

   localparam int InWidth       = 248;
   localparam int OutWidth      = 184;
   localparam int QueueDepth    = 4;
   localparam int QueuePtrWidth = 2;
   localparam int SqrtSteps     = 32;
   localparam int DivSteps      = 17;
   localparam logic [16:0] OneQ16 = 17'd65536;

   // one classified pair as it leaves the front end
   typedef struct packed {
      logic               hit;
      logic [63:0]        sum_sq;
      logic [30:0]        rad;
      logic [29:0]        ra;
      logic signed [30:0] ax;
      logic signed [30:0] ay;
      logic signed [30:0] az;
      logic signed [31:0] dx;
      logic signed [31:0] dy;
      logic signed [31:0] dz;
   } ssc_job_type;

   // per pair data once the distance is known
   typedef struct packed {
      logic               hit;
      logic               zero;
      logic [30:0]        depth;
      logic [31:0]        center_dist;
      logic signed [33:0] lever;
      logic signed [30:0] ax;
      logic signed [30:0] ay;
      logic signed [30:0] az;
      logic [2:0]         neg;
   } ssc_geo_type;

endpackage

/* design/ssc_front.sv */
// front end: differences, squares and the overlap test
`timescale 1ns / 1ps
module ssc_front (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         in_valid,
   output logic                         in_ready,
   input  logic [ssc_pkg::InWidth-1:0]  in_data,
   output logic                         out_valid,
   input  logic                         out_ready,
   output ssc_pkg::ssc_job_type         out_job
);

   logic adv;
   logic v1_ff, v2_ff, v3_ff;
   ssc_pkg::ssc_job_type c1_ff, c1_in, c2_ff, c3_ff, c3_in;
   logic [61:0] sqx_ff, sqy_ff, sqz_ff, rad2_ff;
   logic [61:0] sqx_in, sqy_in, sqz_in, rad2_in;
   logic [30:0] mx, my, mz;
   logic signed [30:0] bx, by, bz;
   logic [29:0] rb;
   logic [63:0] sum;

   assign adv       = !v3_ff || out_ready;
   assign in_ready  = adv;
   assign out_valid = v3_ff;
   assign out_job   = c3_ff;

   always_comb begin
      c1_in    = '0;
      c1_in.ax = in_data[30:0];
      c1_in.ay = in_data[61:31];
      c1_in.az = in_data[92:62];
      c1_in.ra = in_data[122:93];
      bx       = in_data[153:123];
      by       = in_data[184:154];
      bz       = in_data[215:185];
      rb       = in_data[245:216];
      c1_in.dx = 32'(bx) - 32'(c1_in.ax);
      c1_in.dy = 32'(by) - 32'(c1_in.ay);
      c1_in.dz = 32'(bz) - 32'(c1_in.az);
      c1_in.rad = {1'b0, c1_in.ra} + {1'b0, rb};
   end

   always_comb begin
      mx      = 31'(c1_ff.dx[31] ? -c1_ff.dx : c1_ff.dx);
      my      = 31'(c1_ff.dy[31] ? -c1_ff.dy : c1_ff.dy);
      mz      = 31'(c1_ff.dz[31] ? -c1_ff.dz : c1_ff.dz);
      sqx_in  = 62'(mx) * 62'(mx);
      sqy_in  = 62'(my) * 62'(my);
      sqz_in  = 62'(mz) * 62'(mz);
      rad2_in = 62'(c1_ff.rad) * 62'(c1_ff.rad);
   end

   always_comb begin
      sum          = 64'(sqx_ff) + 64'(sqy_ff) + 64'(sqz_ff);
      c3_in        = c2_ff;
      c3_in.sum_sq = sum;
      c3_in.hit    = sum < {2'b00, rad2_ff};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0;
         v2_ff <= 1'b0;
         v3_ff <= 1'b0;
      end else if (adv) begin
         v1_ff <= in_valid;
         v2_ff <= v1_ff;
         v3_ff <= v2_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         c1_ff   <= c1_in;
         c2_ff   <= c1_ff;
         sqx_ff  <= sqx_in;
         sqy_ff  <= sqy_in;
         sqz_ff  <= sqz_in;
         rad2_ff <= rad2_in;
         c3_ff   <= c3_in;
      end
   end

endmodule

/* design/ssc_queue.sv */
// short queue between front end and back end
`timescale 1ns / 1ps
module ssc_queue (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  in_valid,
   output logic                  in_ready,
   input  ssc_pkg::ssc_job_type  in_job,
   output logic                  out_valid,
   input  logic                  out_ready,
   output ssc_pkg::ssc_job_type  out_job
);

   ssc_pkg::ssc_job_type mem_ff [0:ssc_pkg::QueueDepth-1];
   logic [ssc_pkg::QueuePtrWidth-1:0] wr_ff, wr_in, rd_ff, rd_in;
   logic [ssc_pkg::QueuePtrWidth:0]   cnt_ff, cnt_in;
   logic push, pop;

   assign in_ready  = cnt_ff != (ssc_pkg::QueuePtrWidth+1)'(ssc_pkg::QueueDepth);
   assign out_valid = cnt_ff != '0;
   assign out_job   = mem_ff[rd_ff];
   assign push      = in_valid && in_ready;
   assign pop       = out_valid && out_ready;

   always_comb begin
      wr_in  = push ? wr_ff + 1'b1 : wr_ff;
      rd_in  = pop ? rd_ff + 1'b1 : rd_ff;
      cnt_in = cnt_ff + (ssc_pkg::QueuePtrWidth+1)'(push)
                      - (ssc_pkg::QueuePtrWidth+1)'(pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ff  <= '0;
         rd_ff  <= '0;
         cnt_ff <= '0;
      end else begin
         wr_ff  <= wr_in;
         rd_ff  <= rd_in;
         cnt_ff <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         mem_ff[wr_ff] <= in_job;
      end
   end

endmodule

/* design/ssc_back.sv */
// back end: square root, normal division, contact point and result register
`timescale 1ns / 1ps
module ssc_back (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          in_valid,
   output logic                          in_ready,
   input  ssc_pkg::ssc_job_type          in_job,
   output logic                          out_valid,
   input  logic                          out_ready,
   output logic [ssc_pkg::OutWidth-1:0]  out_data,
   output logic                          out_hit
);

   localparam int Sq = ssc_pkg::SqrtSteps;
   localparam int Dv = ssc_pkg::DivSteps;

   logic en;

   // square root pipeline
   logic [Sq:0]          sq_v_ff;
   ssc_pkg::ssc_job_type sq_c_ff    [0:Sq];
   logic [33:0]          sq_rem_ff  [0:Sq];
   logic [33:0]          sq_rem_in  [1:Sq];
   logic [31:0]          sq_root_ff [0:Sq];
   logic [31:0]          sq_root_in [1:Sq];

   // division pipeline, one divider per axis
   logic [Dv:0]          dv_v_ff;
   ssc_pkg::ssc_geo_type dv_g_ff   [0:Dv];
   ssc_pkg::ssc_geo_type dv_g_in;
   logic [32:0]          dv_rem_ff [0:Dv][0:2];
   logic [32:0]          dv_rem_in [0:Dv][0:2];
   logic [16:0]          dv_q_ff   [0:Dv][0:2];
   logic [16:0]          dv_q_in   [0:Dv][0:2];
   logic [16:0]          dv_lo_ff  [0:Dv][0:2];
   logic [16:0]          dv_lo_in  [0:2];

   // multiply stage
   logic                 mu_v_ff;
   ssc_pkg::ssc_geo_type mu_g_ff;
   logic signed [17:0]   mu_n_ff    [0:2];
   logic signed [17:0]   mu_n_in    [0:2];
   logic signed [51:0]   mu_prod_ff [0:2];
   logic signed [51:0]   mu_prod_in [0:2];

   // result register
   logic               o_v_ff;
   logic               o_hit_ff, o_hit_in;
   logic [31:0]        o_pt_ff [0:2];
   logic [31:0]        o_pt_in [0:2];
   logic [17:0]        o_n_ff  [0:2];
   logic [17:0]        o_n_in  [0:2];
   logic [30:0]        o_depth_ff, o_depth_in;

   logic [33:0] sq_t, sq_trial;
   logic [32:0] dv_t;
   logic [30:0] mag [0:2];
   logic [47:0] num [0:2];
   logic signed [31:0] dd [0:2];
   logic signed [30:0] aa [0:2];
   logic [51:0] pmag;
   logic [34:0] pm;
   logic signed [39:0] off, psum;

   assign en        = !o_v_ff || out_ready;
   assign in_ready  = en;
   assign out_valid = o_v_ff;
   assign out_hit   = o_hit_ff;
   assign out_data  = {3'b000, o_depth_ff, o_n_ff[2], o_n_ff[1], o_n_ff[0],
                       o_pt_ff[2], o_pt_ff[1], o_pt_ff[0]};

   // one result bit of the root per stage
   always_comb begin
      for (int k = 0; k < Sq; k++) begin
         sq_t     = {sq_rem_ff[k][31:0], sq_c_ff[k].sum_sq[2*(Sq-1-k) +: 2]};
         sq_trial = {sq_root_ff[k], 2'b01};
         if (sq_t >= sq_trial) begin
            sq_rem_in[k+1]  = sq_t - sq_trial;
            sq_root_in[k+1] = {sq_root_ff[k][30:0], 1'b1};
         end else begin
            sq_rem_in[k+1]  = sq_t;
            sq_root_in[k+1] = {sq_root_ff[k][30:0], 1'b0};
         end
      end
   end

   // depth, lever and dividends
   always_comb begin
      dv_g_in.hit   = sq_c_ff[Sq].hit;
      dv_g_in.center_dist = sq_root_ff[Sq];
      dv_g_in.zero  = sq_root_ff[Sq] == '0;
      dv_g_in.depth = 31'({1'b0, sq_c_ff[Sq].rad} - sq_root_ff[Sq]);
      dv_g_in.lever = 34'(signed'({3'b000, sq_c_ff[Sq].ra, 1'b0}))
                    - 34'(signed'({3'b000, dv_g_in.depth}));
      dv_g_in.ax    = sq_c_ff[Sq].ax;
      dv_g_in.ay    = sq_c_ff[Sq].ay;
      dv_g_in.az    = sq_c_ff[Sq].az;
      dd[0] = sq_c_ff[Sq].dx;
      dd[1] = sq_c_ff[Sq].dy;
      dd[2] = sq_c_ff[Sq].dz;
      for (int i = 0; i < 3; i++) begin
         dv_g_in.neg[i] = dd[i][31];
         mag[i]  = 31'(dd[i][31] ? -dd[i] : dd[i]);
         num[i]  = {1'b0, mag[i], 16'h0000} + {17'h00000, sq_root_ff[Sq][31:1]};
         dv_lo_in[i]     = num[i][16:0];
      end
   end

   // one quotient bit per stage
   always_comb begin
      for (int i = 0; i < 3; i++) begin
         dv_rem_in[0][i] = {2'b00, num[i][47:17]};
         dv_q_in[0][i]   = '0;
      end
      for (int k = 0; k < Dv; k++) begin
         for (int i = 0; i < 3; i++) begin
            dv_t = {dv_rem_ff[k][i][31:0], dv_lo_ff[k][i][Dv-1-k]};
            if (dv_t >= {1'b0, dv_g_ff[k].center_dist}) begin
               dv_rem_in[k+1][i] = dv_t - {1'b0, dv_g_ff[k].center_dist};
               dv_q_in[k+1][i]   = {dv_q_ff[k][i][15:0], 1'b1};
            end else begin
               dv_rem_in[k+1][i] = dv_t;
               dv_q_in[k+1][i]   = {dv_q_ff[k][i][15:0], 1'b0};
            end
         end
      end
   end

   always_comb begin
      for (int i = 0; i < 3; i++) begin
         mu_n_in[i] = dv_g_ff[Dv].neg[i] ? -signed'({1'b0, dv_q_ff[Dv][i]})
                                         : signed'({1'b0, dv_q_ff[Dv][i]});
         mu_prod_in[i] = 52'(mu_n_in[i]) * 52'(dv_g_ff[Dv].lever);
      end
   end

   // rounding, saturation and the special cases
   always_comb begin
      aa[0] = mu_g_ff.ax;
      aa[1] = mu_g_ff.ay;
      aa[2] = mu_g_ff.az;
      o_hit_in   = mu_g_ff.hit;
      o_depth_in = '0;
      for (int i = 0; i < 3; i++) begin
         o_pt_in[i] = '0;
         o_n_in[i]  = '0;
      end
      pmag = '0;
      pm   = '0;
      off  = '0;
      psum = '0;
      if (mu_g_ff.hit && mu_g_ff.zero) begin
         o_depth_in = mu_g_ff.depth;
         o_n_in[1]  = {1'b0, ssc_pkg::OneQ16};
         for (int i = 0; i < 3; i++) begin
            o_pt_in[i] = 32'(aa[i]);
         end
      end else if (mu_g_ff.hit) begin
         o_depth_in = mu_g_ff.depth;
         for (int i = 0; i < 3; i++) begin
            o_n_in[i] = mu_n_ff[i];
            pmag = mu_prod_ff[i][51] ? 52'(-mu_prod_ff[i]) : 52'(mu_prod_ff[i]);
            pm   = 35'((pmag + 52'h1_0000) >> 17);
            off  = mu_prod_ff[i][51] ? -40'(signed'({1'b0, pm}))
                                     : 40'(signed'({1'b0, pm}));
            psum = 40'(aa[i]) + off;
            if (psum > 40'sh007FFF_FFFF) begin
               o_pt_in[i] = 32'h7FFF_FFFF;
            end else if (psum < -40'sh0080000000) begin
               o_pt_in[i] = 32'h8000_0000;
            end else begin
               o_pt_in[i] = psum[31:0];
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         sq_v_ff <= '0;
         dv_v_ff <= '0;
         mu_v_ff <= 1'b0;
         o_v_ff  <= 1'b0;
      end else if (en) begin
         sq_v_ff <= {sq_v_ff[Sq-1:0], in_valid};
         dv_v_ff <= {dv_v_ff[Dv-1:0], sq_v_ff[Sq]};
         mu_v_ff <= dv_v_ff[Dv];
         o_v_ff  <= mu_v_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         sq_c_ff[0]    <= in_job;
         sq_rem_ff[0]  <= '0;
         sq_root_ff[0] <= '0;
         for (int k = 1; k <= Sq; k++) begin
            sq_c_ff[k]    <= sq_c_ff[k-1];
            sq_rem_ff[k]  <= sq_rem_in[k];
            sq_root_ff[k] <= sq_root_in[k];
         end
         dv_g_ff[0] <= dv_g_in;
         for (int i = 0; i < 3; i++) begin
            dv_lo_ff[0][i] <= dv_lo_in[i];
         end
         for (int k = 0; k <= Dv; k++) begin
            if (k > 0) begin
               dv_g_ff[k] <= dv_g_ff[k-1];
            end
            for (int i = 0; i < 3; i++) begin
               dv_rem_ff[k][i] <= dv_rem_in[k][i];
               dv_q_ff[k][i]   <= dv_q_in[k][i];
               if (k > 0) begin
                  dv_lo_ff[k][i] <= dv_lo_ff[k-1][i];
               end
            end
         end
         mu_g_ff <= dv_g_ff[Dv];
         for (int i = 0; i < 3; i++) begin
            mu_n_ff[i]    <= mu_n_in[i];
            mu_prod_ff[i] <= mu_prod_in[i];
            o_pt_ff[i]    <= o_pt_in[i];
            o_n_ff[i]     <= o_n_in[i];
         end
         o_hit_ff   <= o_hit_in;
         o_depth_ff <= o_depth_in;
      end
   end

endmodule

/* design/sphere_sphere_contact_unit.sv */
// top level of the sphere to sphere contact unit
//
// req channel: one sphere pair per transfer, two centres and two radii in
// Q16.16. rsp channel: one result per pair, in order; rsp_tuser is the hit
// flag, rsp_tdata carries contact point, unit normal and depth (all zero on
// a miss).
// a new pair can be taken every cycle unless the front end is held. the
// path from request transfer to result valid runs through 3 front stages
// (differences, squares, overlap compare), the queue, 33 square root
// stages, 18 divider stages, one multiply stage and the result register.
// the square root and the three 17 bit dividers are fully pipelined, one
// result bit per stage.
// when the receiver stalls, the back pipeline holds as a whole while the
// four entry queue keeps taking classified pairs; the front end stops when
// the queue is full and its last stage holds a pair.
// synchronous reset empties all stages and the queue; no other state.
`timescale 1ns / 1ps
module sphere_sphere_contact_unit (
   input  logic         clock,
   input  logic         reset,
   input  logic         req_tvalid,
   output logic         req_tready,
   // first_x, first_y, first_z, first_radius, second_x, second_y, second_z,
   // second_radius, zero pad
   input  logic [247:0] req_tdata,
   output logic         rsp_tvalid,
   input  logic         rsp_tready,
   // point_x, point_y, point_z, normal_x, normal_y, normal_z, contact_depth,
   // zero pad
   output logic [183:0] rsp_tdata,
   // hit
   output logic         rsp_tuser
);

   logic                 f_valid, f_ready, b_valid, b_ready;
   ssc_pkg::ssc_job_type f_job, b_job;

   ssc_front u_front (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (req_tvalid),
      .in_ready  (req_tready),
      .in_data   (req_tdata),
      .out_valid (f_valid),
      .out_ready (f_ready),
      .out_job   (f_job)
   );

   ssc_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (f_valid),
      .in_ready  (f_ready),
      .in_job    (f_job),
      .out_valid (b_valid),
      .out_ready (b_ready),
      .out_job   (b_job)
   );

   ssc_back u_back (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (b_valid),
      .in_ready  (b_ready),
      .in_job    (b_job),
      .out_valid (rsp_tvalid),
      .out_ready (rsp_tready),
      .out_data  (rsp_tdata),
      .out_hit   (rsp_tuser)
   );

endmodule

/* design/ssc_checker.sv */
// port level checks of the sphere contact unit
`timescale 1ns / 1ps
module ssc_checker (
   input logic         clock,
   input logic         reset,
   input logic         req_tvalid,
   input logic         req_tready,
   input logic [247:0] req_tdata,
   input logic         rsp_tvalid,
   input logic         rsp_tready,
   input logic [183:0] rsp_tdata,
   input logic         rsp_tuser
);

   // stalled result holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata)
                                    && $stable(rsp_tuser))
      else $error("stalled result changed");

   // a miss carries all zero fields
   a_miss_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tuser |-> rsp_tdata == '0)
      else $error("miss with nonzero fields");

   // a hit always has some penetration
   a_hit_depth: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tuser |-> rsp_tdata[180:150] != '0)
      else $error("hit with zero depth");

   // x and y normal components stay within unit length
   a_norm_range: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> ($signed(rsp_tdata[131:114]) <= 18'sd65536)
                  && ($signed(rsp_tdata[131:114]) >= -18'sd65536)
                  && ($signed(rsp_tdata[113:96]) <= 18'sd65536)
                  && ($signed(rsp_tdata[113:96]) >= -18'sd65536))
      else $error("normal out of range");

   // nothing comes out right after reset
   a_reset_idle: assert property (@(posedge clock)
      $past(reset) |-> !rsp_tvalid)
      else $error("result valid right after reset");

endmodule

bind sphere_sphere_contact_unit ssc_checker u_ssc_checker (.*);
